// ===== rtl/kpe_pkg.sv =====
// kpe_pkg: shared types, codes and helpers for the key press event detector
// depends on nothing; used by kpe_evq and key_press_event_detector
package kpe_pkg;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // event queue depth and pointer width
  localparam int EVQ_DEPTH = 16;
  localparam int EVQ_AW = $clog2(EVQ_DEPTH);
  // most events one key slot can push at once (pending, long press, repeat)
  localparam int EVQ_PUSH_MAX = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [1:0] CFG_REPEAT = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_LONG    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_CLICK  = 2'd0,
    EV_LONG   = 2'd1,
    EV_REPEAT = 2'd2
  } evt_code_t;

  typedef struct packed {
    phase_t            phase;
    logic              held;
    logic              prev;
    logic [CNT_W-1:0]  press;
    logic [CNT_W-1:0]  hold;
  } key_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

// ===== rtl/kpe_evq.sv =====
// kpe_evq: event queue, up to three pushes and one pop per cycle
// depends on kpe_pkg for depth and push width
module kpe_evq #(
  parameter int W = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             push_cnt,
  input  logic [2:0][W-1:0]      push_data,
  input  logic                   pop,
  output logic [W-1:0]           head,
  output logic                   not_empty,
  output logic [kpe_pkg::EVQ_AW:0] count
);

  localparam int AW = kpe_pkg::EVQ_AW;

  logic [W-1:0]  mem [kpe_pkg::EVQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + (AW+1)'(push_cnt) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < kpe_pkg::EVQ_PUSH_MAX; k++) begin
      if (2'(k) < push_cnt) begin
        mem[wr_ptr_r + AW'(k)] <= push_data[k];
      end
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

// ===== rtl/key_press_event_detector.sv =====
// key_press_event_detector: top level, per-key state memory with read-modify-write
// depends on kpe_pkg and kpe_evq
//
// One input transaction is one scan tick with a pressed bit per key. The scan is
// walked one key per cycle: the key's state entry is read from a small synchronous
// state memory, updated (debounce count, phase, hold count) and written back the
// next cycle. A scan is accepted, then occupies the state memory until all of its
// keys are walked, and no new scan is taken before that; the key walk pauses while
// the event queue is close to full. Events (click, long press, repeat) leave
// through a 16 entry event queue in key order, one per cycle unless out_stall
// holds them, and the final event of a scan carries last_event. One event is
// held back until the next one or the end of the scan is known, so the last mark
// is set correctly. A scan with no events produces no output transaction. The
// state memory resets to idle through per-entry valid bits, with no clearing pass.
// Configuration writes are meant for idle periods only.
module key_press_event_detector #(
  parameter int KEY_COUNT = 5,
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // scan input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KEY_COUNT-1:0]  in_pressed_mask,
  // event output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KW-1:0]         out_key_index,
  output logic [1:0]            out_event_code,
  output logic                  out_last_event,
  // configuration
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // room needed before a key is read: one slot in flight plus this one
  localparam int ISSUE_LIMIT = kpe_pkg::EVQ_DEPTH - 2 * kpe_pkg::EVQ_PUSH_MAX;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [1:0]    code;
    logic          last;
  } evt_t;

  localparam int EW = $bits(evt_t);

  // configuration registers
  logic [15:0] debounce_r, long_press_r, repeat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= 16'd3;
      long_press_r <= 16'd100;
      repeat_r     <= 16'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        kpe_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        kpe_pkg::CFG_LONG_PRESS: long_press_r <= cfg_data;
        kpe_pkg::CFG_REPEAT:     repeat_r     <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // scan walker
  logic                 scan_active_r;
  logic [KEY_COUNT-1:0] mask_r;
  logic [KW-1:0]        key_r;
  logic                 rd_en;
  logic                 rd_last;
  logic                 in_take;
  logic [kpe_pkg::EVQ_AW:0] evq_count;

  assign in_stall = scan_active_r;
  assign in_take  = in_valid && !scan_active_r;
  // only read a key when the queue can absorb its events and those in flight
  assign rd_en    = scan_active_r && (evq_count <= (kpe_pkg::EVQ_AW+1)'(ISSUE_LIMIT));
  assign rd_last  = (key_r == KW'(KEY_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_active_r <= 1'b0;
      key_r         <= '0;
    end else if (in_take) begin
      scan_active_r <= 1'b1;
      key_r         <= '0;
    end else if (rd_en) begin
      key_r <= key_r + KW'(1);
      if (rd_last) begin
        scan_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mask_r <= in_pressed_mask;
    end
  end

  // state memory, one entry per key, registered read
  kpe_pkg::key_state_t mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] ent_valid_r;
  kpe_pkg::key_state_t  rd_data_r;
  logic                 rd_hit_r;

  // update stage
  logic          s1_valid_r;
  logic [KW-1:0] s1_key_r;
  logic          s1_raw_r;
  logic          s1_last_r;

  kpe_pkg::key_state_t st_cur, st_nxt;
  logic ev_first, ev_rep;
  kpe_pkg::evt_code_t ev_first_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[key_r];
      rd_hit_r  <= ent_valid_r[key_r];
      s1_key_r  <= key_r;
      s1_raw_r  <= mask_r[key_r];
      s1_last_r <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mem[s1_key_r] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else if (s1_valid_r) begin
      ent_valid_r[s1_key_r] <= 1'b1;
    end
  end

  // per-key update: debounce, phase progression, event detection
  always_comb begin
    logic [15:0] pc;
    logic [15:0] hc;
    kpe_pkg::phase_t ph;

    // entry never written reads as the reset state
    st_cur = rd_hit_r ? rd_data_r : '0;
    pc = st_cur.press;
    hc = st_cur.hold;
    ph = st_cur.phase;
    st_nxt = st_cur;
    ev_first = 1'b0;
    ev_first_code = kpe_pkg::EV_CLICK;
    ev_rep = 1'b0;

    if (s1_raw_r && st_cur.prev) begin
      pc = kpe_pkg::sat_inc(pc);
    end else begin
      pc = '0;
      hc = '0;
    end
    st_nxt.prev = s1_raw_r;

    if (pc >= debounce_r) begin
      st_nxt.held = 1'b1;
      if (ph == kpe_pkg::PH_IDLE) begin
        ph = kpe_pkg::PH_PRESSED;
        pc = '0;
      end
      if (ph == kpe_pkg::PH_PRESSED) begin
        // pressed keys count a second time per scan
        pc = kpe_pkg::sat_inc(pc);
        if (pc >= long_press_r) begin
          ev_first = 1'b1;
          ev_first_code = kpe_pkg::EV_LONG;
          ph = kpe_pkg::PH_LONG;
          hc = '0;
        end
      end
      if (ph == kpe_pkg::PH_LONG) begin
        hc = kpe_pkg::sat_inc(hc);
        if (hc >= repeat_r) begin
          ev_rep = 1'b1;
          hc = '0;
        end
      end
    end else if (st_cur.held && !s1_raw_r) begin
      // release, not debounced
      if (ph == kpe_pkg::PH_PRESSED && pc < long_press_r) begin
        ev_first = 1'b1;
        ev_first_code = kpe_pkg::EV_CLICK;
      end
      ph = kpe_pkg::PH_IDLE;
      st_nxt.held = 1'b0;
      pc = '0;
      hc = '0;
    end

    st_nxt.phase = ph;
    st_nxt.press = pc;
    st_nxt.hold  = hc;
  end

  // event ordering: one event stays pending until the next one or scan end
  logic pend_valid_r;
  evt_t pend_r;
  logic [1:0]      push_cnt;
  logic [2:0][EW-1:0] push_data;
  logic            pend_valid_nxt;
  evt_t            pend_nxt;

  always_comb begin
    evt_t lst [3];
    logic [1:0] n;

    n = 2'd0;
    for (int k = 0; k < 3; k++) begin
      lst[k] = '0;
    end
    if (pend_valid_r) begin
      lst[n] = pend_r;
      n = n + 2'd1;
    end
    if (ev_first) begin
      lst[n] = '{key: s1_key_r, code: ev_first_code, last: 1'b0};
      n = n + 2'd1;
    end
    if (ev_rep) begin
      lst[n] = '{key: s1_key_r, code: kpe_pkg::EV_REPEAT, last: 1'b0};
      n = n + 2'd1;
    end

    push_cnt = 2'd0;
    pend_valid_nxt = pend_valid_r;
    pend_nxt = pend_r;
    if (s1_valid_r) begin
      if (s1_last_r) begin
        // end of scan: flush everything, mark the final event
        if (n != 2'd0) begin
          lst[n - 2'd1].last = 1'b1;
        end
        push_cnt = n;
        pend_valid_nxt = 1'b0;
      end else if (n != 2'd0) begin
        push_cnt = n - 2'd1;
        pend_valid_nxt = 1'b1;
        pend_nxt = lst[n - 2'd1];
      end
    end

    for (int k = 0; k < 3; k++) begin
      push_data[k] = lst[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  // output queue
  logic [EW-1:0] evq_head;
  evt_t          head_evt;
  logic          evq_pop;

  assign evq_pop = out_valid && !out_stall;

  kpe_evq #(
    .W (EW)
  ) u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .pop       (evq_pop),
    .head      (evq_head),
    .not_empty (out_valid),
    .count     (evq_count)
  );

  assign head_evt       = evt_t'(evq_head);
  assign out_key_index  = head_evt.key;
  assign out_event_code = head_evt.code;
  assign out_last_event = head_evt.last;

  // read and write-back never target the same entry in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && s1_valid_r) |-> (key_r != s1_key_r))
    else $error("state memory read collides with write-back");

  // the queue never holds more than its depth
  a_evq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    evq_count <= (kpe_pkg::EVQ_AW+1)'(kpe_pkg::EVQ_DEPTH))
    else $error("event queue overflow");

  // end of scan leaves nothing pending
  a_scan_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) |=> !pend_valid_r)
    else $error("pending event survived end of scan");

  // an accepted scan starts the key walk
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (scan_active_r && key_r == '0))
    else $error("scan accepted without starting key walk");

endmodule
